[rtl/core/rbd_pkg.sv]
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;

  // Widths of the fixed port fields.
  localparam int MODE_W = 2;
  localparam int DATA_W = 32;

  // Bits actually kept per entry; data port bits above the stored width read as zero.
  localparam int STORE_W = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ZERO = '0;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [STORE_W-1:0] entry_t;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Store access issued by the control logic in the accept cycle.
  typedef struct packed {
    logic   we;
    logic   re;
    idx_t   addr;
    entry_t wdata;
  } mem_req_t;

  // Registered result status of one word.
  typedef struct packed {
    logic valid;
    logic failed;
    logic now_empty;
    logic now_full;
    logic pop_ok;
  } res_t;

endpackage

[rtl/core/rbd_store.sv]
`timescale 1ns / 1ps

module rbd_store (
  input  logic              clk,
  input  rbd_pkg::mem_req_t req,
  output rbd_pkg::entry_t   rd_data
);
  import rbd_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem_r[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/rbd_ctrl.sv]
`timescale 1ns / 1ps

module rbd_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       take,
  input  logic [rbd_pkg::MODE_W-1:0] mode,
  input  logic [rbd_pkg::DATA_W-1:0] item_value,
  output rbd_pkg::mem_req_t          req,
  output rbd_pkg::res_t              res
);
  import rbd_pkg::*;

  idx_t back_r,   back_nxt;
  idx_t front_r,  front_nxt;
  logic parity_r, parity_nxt;
  res_t res_r,    res_nxt;

  op_t  op;
  logic is_empty;
  logic is_full;
  logic fail;

  assign op       = op_t'(mode);
  assign is_empty = (back_r == front_r) && !parity_r;
  assign is_full  = (back_r == front_r) &&  parity_r;

  always_comb begin
    back_nxt   = back_r;
    front_nxt  = front_r;
    parity_nxt = parity_r;
    fail       = 1'b0;
    req.we     = 1'b0;
    req.re     = 1'b0;
    req.addr   = back_r;
    req.wdata  = item_value[STORE_W-1:0];

    unique case (op)
      OP_PUSH_BACK: begin
        fail     = is_full;
        req.we   = accept && !is_full;
        req.addr = back_r;
        if (!is_full) begin
          back_nxt = (back_r == IDX_LAST) ? IDX_ZERO : back_r + 1'b1;
          if (back_r == IDX_LAST) parity_nxt = !parity_r;
        end
      end
      OP_PUSH_FRONT: begin
        // The front pointer retreats first, then the entry lands there.
        front_nxt = (front_r == IDX_ZERO) ? IDX_LAST : front_r - 1'b1;
        fail      = is_full;
        req.we    = accept && !is_full;
        req.addr  = front_nxt;
        if (is_full) begin
          front_nxt = front_r;
        end else if (front_r == IDX_ZERO) begin
          parity_nxt = !parity_r;
        end
      end
      OP_POP_FRONT: begin
        fail     = is_empty;
        req.re   = accept && !is_empty;
        req.addr = front_r;
        if (!is_empty) begin
          front_nxt = (front_r == IDX_LAST) ? IDX_ZERO : front_r + 1'b1;
          if (front_r == IDX_LAST) parity_nxt = !parity_r;
        end
      end
      OP_POP_BACK: begin
        back_nxt = (back_r == IDX_ZERO) ? IDX_LAST : back_r - 1'b1;
        fail     = is_empty;
        req.re   = accept && !is_empty;
        req.addr = back_nxt;
        if (is_empty) begin
          back_nxt = back_r;
        end else if (back_r == IDX_ZERO) begin
          parity_nxt = !parity_r;
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase

    res_nxt = res_r;
    if (accept) begin
      res_nxt.valid     = 1'b1;
      res_nxt.failed    = fail;
      res_nxt.now_empty = (back_nxt == front_nxt) && !parity_nxt;
      res_nxt.now_full  = (back_nxt == front_nxt) &&  parity_nxt;
      res_nxt.pop_ok    = !fail && (op == OP_POP_FRONT || op == OP_POP_BACK);
    end else if (take) begin
      res_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_r    <= '0;
      front_r   <= '0;
      parity_r  <= 1'b0;
      res_r     <= '0;
    end else begin
      res_r <= res_nxt;
      if (accept) begin
        back_r   <= back_nxt;
        front_r  <= front_nxt;
        parity_r <= parity_nxt;
      end
    end
  end

  assign res = res_r;

endmodule

[rtl/core/ring_buffer_deque.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_mode, in_item_value
// out_     output     out_valid/out_stall out_data_out, out_failed, out_now_empty, out_now_full
//
// One word per cycle while no result is held by out_stall: the result of an accepted word is
// registered, from the pointer update and the single registered read port of the entry store.
// Reset is synchronous and active low; it empties the queue, the store keeps its contents.
// A result held by out_stall stalls the input; a new word is taken in the cycle the
// pending result is taken.

module ring_buffer_deque (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rbd_pkg::MODE_W-1:0] in_mode,
  input  logic [rbd_pkg::DATA_W-1:0] in_item_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rbd_pkg::DATA_W-1:0] out_data_out,
  output logic                       out_failed,
  output logic                       out_now_empty,
  output logic                       out_now_full
);
  import rbd_pkg::*;

  mem_req_t req;
  res_t     res;
  entry_t   rd_data;
  logic     accept;
  logic     take;

  assign take     = res.valid && !out_stall;
  assign in_stall = res.valid && out_stall;
  assign accept   = in_valid && !in_stall;

  rbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .take       (take),
    .mode       (in_mode),
    .item_value (in_item_value),
    .req        (req),
    .res        (res)
  );

  rbd_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign out_valid     = res.valid;
  assign out_failed    = res.failed;
  assign out_now_empty = res.now_empty;
  assign out_now_full  = res.now_full;
  // Only a successful pop shows store data; everything else reads as zero.
  assign out_data_out  = res.pop_ok ? DATA_W'(rd_data) : '0;

endmodule

[rtl/core/rbd_checker.sv]
`timescale 1ns / 1ps

module rbd_assertions (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [rbd_pkg::MODE_W-1:0] in_mode,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rbd_pkg::DATA_W-1:0] out_data_out,
  input logic                       out_failed,
  input logic                       out_now_empty,
  input logic                       out_now_full
);

  // A held result keeps its word until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out) && $stable(out_failed)
      && $stable(out_now_empty) && $stable(out_now_full))
    else $error("result changed while stalled");

  // The input side only waits on a result that is stuck.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_now_empty && out_now_full))
    else $error("queue reported empty and full together");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failed |-> out_data_out == '0)
    else $error("failed operation returned data");

  // A pop that works can never leave the queue full; the property below checks that a push can never leave it empty.
  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_mode[0] |=> out_valid && !out_now_empty)
    else $error("push left the queue empty");

endmodule

bind ring_buffer_deque rbd_assertions u_rbd_assertions (.*);

[tb/sv/rbd_checker.sv]
`timescale 1ns / 1ps

module rbd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [rbd_pkg::MODE_W-1:0] in_mode,
  input  logic [rbd_pkg::DATA_W-1:0] in_item_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [rbd_pkg::DATA_W-1:0] out_data_out,
  input  logic                       out_failed,
  input  logic                       out_now_empty,
  input  logic                       out_now_full,
  output int                         fail_count,
  output int                         pending_words,
  output int                         words_checked,
  output int                         rejected_words,
  output int                         full_words,
  output int                         empty_words
);

  import rbd_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              failed;
    logic              now_empty;
    logic              now_full;
  } deque_result_t;

  // Shadow copy of the queue.
  entry_t        entries [DEPTH];
  idx_t          back_idx;
  idx_t          front_idx;
  logic          wrap_par;
  deque_result_t expected_results[$];

  initial begin
    fail_count     = 0;
    pending_words  = 0;
    words_checked  = 0;
    rejected_words = 0;
    full_words     = 0;
    empty_words    = 0;
  end

  function automatic idx_t idx_inc(idx_t i);
    return (i == IDX_LAST) ? IDX_ZERO : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    return (i == IDX_ZERO) ? IDX_LAST : idx_t'(i - 1'b1);
  endfunction

  function automatic deque_result_t apply_deque_op(op_t op, logic [DATA_W-1:0] value);
    deque_result_t r;
    logic          is_full;
    logic          is_empty;
    r        = '0;
    is_full  = (back_idx == front_idx) && wrap_par;
    is_empty = (back_idx == front_idx) && !wrap_par;
    case (op)
      OP_PUSH_BACK: begin
        if (is_full) begin
          r.failed = 1'b1;
        end else begin
          entries[back_idx] = entry_t'(value);
          back_idx          = idx_inc(back_idx);
          if (back_idx == IDX_ZERO) wrap_par = ~wrap_par;
        end
      end
      OP_PUSH_FRONT: begin
        if (is_full) begin
          r.failed = 1'b1;
        end else begin
          if (front_idx == IDX_ZERO) wrap_par = ~wrap_par;
          front_idx          = idx_dec(front_idx);
          entries[front_idx] = entry_t'(value);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          r.failed = 1'b1;
        end else begin
          r.data    = DATA_W'(entries[front_idx]);
          front_idx = idx_inc(front_idx);
          if (front_idx == IDX_ZERO) wrap_par = ~wrap_par;
        end
      end
      default: begin
        if (is_empty) begin
          r.failed = 1'b1;
        end else begin
          if (back_idx == IDX_ZERO) wrap_par = ~wrap_par;
          back_idx = idx_dec(back_idx);
          r.data   = DATA_W'(entries[back_idx]);
        end
      end
    endcase
    r.now_empty = (back_idx == front_idx) && !wrap_par;
    r.now_full  = (back_idx == front_idx) && wrap_par;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      back_idx  = IDX_ZERO;
      front_idx = IDX_ZERO;
      wrap_par  = 1'b0;
      expected_results.delete();
    end else begin
      // The result of a word never leaves at the edge that accepts it, so the
      // result side is handled first.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result word with no operation pending, data %0h",
                   $time, out_data_out);
        end else begin
          want = expected_results.pop_front();
          check_field("data_out", want.data, out_data_out);
          check_field("failed", DATA_W'(want.failed), DATA_W'(out_failed));
          check_field("now_empty", DATA_W'(want.now_empty), DATA_W'(out_now_empty));
          check_field("now_full", DATA_W'(want.now_full), DATA_W'(out_now_full));
          words_checked++;
          if (want.failed) rejected_words++;
          if (want.now_full) full_words++;
          if (want.now_empty) empty_words++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_deque_op(op_t'(in_mode), in_item_value));
      end
    end
    pending_words <= expected_results.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  import rbd_pkg::*;

  localparam int RANDOM_WORDS = 725;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 120;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode       = '0;
  logic [DATA_W-1:0] in_item_value = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [DATA_W-1:0] out_data_out;
  logic              out_failed;
  logic              out_now_empty;
  logic              out_now_full;

  int fail_count;
  int pending_words;
  int words_checked;
  int rejected_words;
  int full_words;
  int empty_words;
  int words_sent = 0;
  bit burst      = 1'b0;

  always #5 clk = ~clk;

  ring_buffer_deque i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_item_value(in_item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_failed   (out_failed),
    .out_now_empty(out_now_empty),
    .out_now_full (out_now_full)
  );

  rbd_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_out  (out_data_out),
    .out_failed    (out_failed),
    .out_now_empty (out_now_empty),
    .out_now_full  (out_now_full),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .rejected_words(rejected_words),
    .full_words    (full_words),
    .empty_words   (empty_words)
  );

  task automatic send_word(input op_t op, input logic [DATA_W-1:0] value);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= op;
    in_item_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // The pending count is a registered copy of the checker's queue size.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Result side: a random hold-off before each word outside bursts, and one long hold that
  // backs the block up while the sender keeps offering words.
  initial begin
    int wait_cycles;
    int taken;
    taken = 0;
    forever begin
      if (taken == HOLD_AT) wait_cycles = HOLD_CYCLES;
      else wait_cycles = burst ? 0 : $urandom_range(0, 16);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int   phase_len;
    int   push_pct;
    int   phase_no;
    op_t  op;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Pops on an empty queue, a push of each data extreme and its pops, then fill to full from
    // both ends, push twice more into the full queue and pop once.
    send_word(OP_POP_FRONT, '1);
    send_word(OP_POP_BACK, '0);
    send_word(OP_PUSH_BACK, '0);
    send_word(OP_PUSH_FRONT, '1);
    send_word(OP_POP_BACK, $urandom);
    send_word(OP_POP_FRONT, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      send_word(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
    end
    send_word(OP_PUSH_BACK, $urandom);
    send_word(OP_PUSH_FRONT, '1);
    send_word(OP_POP_BACK, $urandom);

    // Phases with a push bias of 15, 50 or 85 percent, so that the queue swings between empty and full.
    phase_no = 0;
    while (words_sent < RANDOM_WORDS + 25) begin
      phase_len = $urandom_range(20, 50);
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        end
        send_word(op, $urandom);
      end
      phase_no++;
      if (phase_no % 6 == 0) drain_results();
    end

    burst = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d operations; %0d result words checked, %0d rejected,", words_sent,
             words_checked, rejected_words);
    $display("%0d left the queue full and %0d left it empty.", full_words, empty_words);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d words still expected.", pending_words);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
rtl/core/rbd_pkg.sv
rtl/core/rbd_store.sv
rtl/core/rbd_ctrl.sv
rtl/core/ring_buffer_deque.sv
rtl/core/rbd_checker.sv
tb/sv/rbd_checker.sv
tb/sv/tb_top.sv
